[hw/rtl/isp_pkg.sv]
// shared types and codes for the implicit shape point classifier
// no dependencies; imported by every module of the block
package isp_pkg;

  typedef enum logic [1:0] {
    SHAPE_SPHERE   = 2'd0,
    SHAPE_CYLINDER = 2'd1,
    SHAPE_CUBE     = 2'd2,
    SHAPE_TORUS    = 2'd3
  } shape_t;

  localparam int unsigned CFG_INDEX_BITS = 3;

  localparam logic [CFG_INDEX_BITS-1:0] REG_SHAPE      = 3'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_SURFACE    = 3'd1;
  localparam logic [CFG_INDEX_BITS-1:0] REG_SIZE_MAIN  = 3'd2;
  localparam logic [CFG_INDEX_BITS-1:0] REG_SIZE_MINOR = 3'd3;
  localparam logic [CFG_INDEX_BITS-1:0] REG_TOLERANCE  = 3'd4;

  typedef struct packed {
    shape_t shape;
    logic   surface;
  } cfg_ctrl_t;

endpackage

[hw/rtl/implicit_shape_point_classifier.sv]
// Implicit shape point classifier: tests one signed fixed-point point per beat against a
// sphere, cylinder, cube or torus centred at the origin, in volume or surface-band mode,
// with exact wide-integer compares. A point is taken every clock while the output is not
// held; the pipeline depth is set by the torus path (squares, sums, split half-width
// products, their sums, difference, band test).
// Stalls on the output back up stage by stage, so empty stages keep taking points.
// Configuration writes are always accepted and must only occur while no point is in flight.
module implicit_shape_point_classifier import isp_pkg::*; #(
  parameter int COORD_BITS = 16
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [CFG_INDEX_BITS-1:0]    cfg_index,
  input  logic [COORD_BITS:0]          cfg_data,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic signed [COORD_BITS-1:0] point_x,
  input  logic signed [COORD_BITS-1:0] point_y,
  input  logic signed [COORD_BITS-1:0] point_z,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic                         accepted
);

  localparam int CW = COORD_BITS;

  cfg_ctrl_t         ctrl;
  logic [CW:0]       size_main, size_minor;
  logic [CW-1:0]     tolerance;
  logic              f_valid, f_ready, t_valid, t_ready;
  logic [2*CW-1:0]   q, s;
  logic [2*CW+2:0]   u;
  logic [2*CW+1:0]   r2_main, r2_minor;
  logic [CW-1:0]     mx;
  logic [4*CW+5:0]   lhs, rhs;
  logic [2*CW-1:0]   slhs;
  logic [2*CW+1:0]   srhs;

  isp_cfg #(.CW(CW)) u_cfg (
    .clk        (clk),
    .rst        (rst),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .ctrl       (ctrl),
    .size_main  (size_main),
    .size_minor (size_minor),
    .tolerance  (tolerance)
  );

  isp_front #(.CW(CW)) u_front (
    .clk        (clk),
    .rst        (rst),
    .up_valid   (in_valid),
    .up_ready   (in_ready),
    .point_x    (point_x),
    .point_y    (point_y),
    .point_z    (point_z),
    .size_main  (size_main),
    .size_minor (size_minor),
    .dn_valid   (f_valid),
    .dn_ready   (f_ready),
    .q          (q),
    .s          (s),
    .u          (u),
    .r2_main    (r2_main),
    .r2_minor   (r2_minor),
    .mx         (mx)
  );

  isp_torus #(.CW(CW)) u_torus (
    .clk       (clk),
    .rst       (rst),
    .ctrl      (ctrl),
    .size_main (size_main),
    .up_valid  (f_valid),
    .up_ready  (f_ready),
    .q         (q),
    .s         (s),
    .u         (u),
    .r2_main   (r2_main),
    .r2_minor  (r2_minor),
    .mx        (mx),
    .dn_valid  (t_valid),
    .dn_ready  (t_ready),
    .lhs       (lhs),
    .rhs       (rhs),
    .slhs      (slhs),
    .srhs      (srhs)
  );

  isp_decide #(.CW(CW)) u_decide (
    .clk       (clk),
    .rst       (rst),
    .ctrl      (ctrl),
    .tolerance (tolerance),
    .up_valid  (t_valid),
    .up_ready  (t_ready),
    .lhs       (lhs),
    .rhs       (rhs),
    .slhs      (slhs),
    .srhs      (srhs),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .accepted  (accepted)
  );

endmodule

[hw/rtl/isp_cfg.sv]
// configuration register file: shape, mode, sizes and tolerance
// depends on isp_pkg
module isp_cfg import isp_pkg::*; #(
  parameter int CW = 16
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [CW:0]               cfg_data,
  output cfg_ctrl_t                 ctrl,
  output logic [CW:0]               size_main,
  output logic [CW:0]               size_minor,
  output logic [CW-1:0]             tolerance
);

  localparam logic [63:0] SCALE     = 64'd1 << CW;
  localparam logic [CW:0] MAIN_RST  = (CW+1)'(SCALE >> 1);
  localparam logic [CW:0] MINOR_RST = (CW+1)'((SCALE * 64'd2 + 64'd5) / 64'd10);
  localparam logic [CW-1:0] TOL_RST = CW'((SCALE + 64'd500) / 64'd1000);

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      ctrl.shape   <= SHAPE_SPHERE;
      ctrl.surface <= 1'b0;
      size_main    <= MAIN_RST;
      size_minor   <= MINOR_RST;
      tolerance    <= TOL_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_SHAPE:      ctrl.shape   <= shape_t'(cfg_data[1:0]);
        REG_SURFACE:    ctrl.surface <= cfg_data[0];
        REG_SIZE_MAIN:  size_main    <= cfg_data;
        REG_SIZE_MINOR: size_minor   <= cfg_data;
        REG_TOLERANCE:  tolerance    <= cfg_data[CW-1:0];
        default: ;
      endcase
    end
  end

  a_main_write: assert property (@(posedge clk) disable iff (rst)
    cfg_valid && cfg_ready && cfg_index == REG_SIZE_MAIN |=> size_main == $past(cfg_data))
    else $error("size_main not taken from write beat");

  a_stray_write: assert property (@(posedge clk) disable iff (rst)
    cfg_valid && cfg_ready && cfg_index != REG_SHAPE && cfg_index != REG_SURFACE &&
    cfg_index != REG_SIZE_MAIN && cfg_index != REG_SIZE_MINOR &&
    cfg_index != REG_TOLERANCE
    |=> $stable(ctrl) && $stable(size_main) && $stable(size_minor) && $stable(tolerance))
    else $error("write beyond register list changed state");

endmodule

[hw/rtl/isp_front.sv]
// front stages: coordinate magnitudes, squares, radius squares and sums
// depends on isp_pkg; feeds isp_torus
module isp_front import isp_pkg::*; #(
  parameter int CW = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 up_valid,
  output logic                 up_ready,
  input  logic signed [CW-1:0] point_x,
  input  logic signed [CW-1:0] point_y,
  input  logic signed [CW-1:0] point_z,
  input  logic [CW:0]          size_main,
  input  logic [CW:0]          size_minor,
  output logic                 dn_valid,
  input  logic                 dn_ready,
  output logic [2*CW-1:0]      q,
  output logic [2*CW-1:0]      s,
  output logic [2*CW+2:0]      u,
  output logic [2*CW+1:0]      r2_main,
  output logic [2*CW+1:0]      r2_minor,
  output logic [CW-1:0]        mx
);

  localparam int NS = 3;

  logic [NS-1:0]   vld;
  logic [NS-1:0]   ld;
  logic [CW-1:0]   ax, ay, az, mx_in;
  // stage a
  logic [2*CW-1:0] sqx_a, sqy_a, sqz_a;
  logic [2*CW+1:0] r2m_a, r2n_a;
  logic [CW-1:0]   mx_a;
  // stage b
  logic [2*CW-1:0] q_b, sqz_b;
  logic [2*CW+2:0] zr_b;
  logic [2*CW+1:0] r2m_b, r2n_b;
  logic [CW-1:0]   mx_b;

  always_comb begin
    ld[NS-1] = !vld[NS-1] || dn_ready;
    for (int k = NS - 2; k >= 0; k--) begin
      ld[k] = !vld[k] || ld[k+1];
    end
  end

  assign up_ready = ld[0];
  assign dn_valid = vld[NS-1];

  always_comb begin
    ax = point_x[CW-1] ? $unsigned(-point_x) : $unsigned(point_x);
    ay = point_y[CW-1] ? $unsigned(-point_y) : $unsigned(point_y);
    az = point_z[CW-1] ? $unsigned(-point_z) : $unsigned(point_z);
    mx_in = (ax > ay) ? ax : ay;
    if (az > mx_in) begin
      mx_in = az;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (ld[0]) vld[0] <= up_valid;
      if (ld[1]) vld[1] <= vld[0];
      if (ld[2]) vld[2] <= vld[1];
    end
  end

  always_ff @(posedge clk) begin
    if (ld[0]) begin
      sqx_a <= (2*CW)'(ax) * (2*CW)'(ax);
      sqy_a <= (2*CW)'(ay) * (2*CW)'(ay);
      sqz_a <= (2*CW)'(az) * (2*CW)'(az);
      r2m_a <= (2*CW+2)'(size_main) * (2*CW+2)'(size_main);
      r2n_a <= (2*CW+2)'(size_minor) * (2*CW+2)'(size_minor);
      mx_a  <= mx_in;
    end
    if (ld[1]) begin
      q_b   <= sqx_a + sqy_a;
      zr_b  <= (2*CW+3)'(sqz_a) + (2*CW+3)'(r2m_a);
      sqz_b <= sqz_a;
      r2m_b <= r2m_a;
      r2n_b <= r2n_a;
      mx_b  <= mx_a;
    end
    if (ld[2]) begin
      q        <= q_b;
      s        <= q_b + sqz_b;
      u        <= (2*CW+3)'(q_b) + zr_b;
      r2_main  <= r2m_b;
      r2_minor <= r2n_b;
      mx       <= mx_b;
    end
  end

endmodule

[hw/rtl/isp_torus.sv]
// torus product path: |s+R^2-r^2| squared and 4 R^2 q, split into half-width products
// also carries the small compare pair for sphere, cylinder and cube; depends on isp_pkg
module isp_torus import isp_pkg::*; #(
  parameter int CW = 16
) (
  input  logic              clk,
  input  logic              rst,
  input  cfg_ctrl_t         ctrl,
  input  logic [CW:0]       size_main,
  input  logic              up_valid,
  output logic              up_ready,
  input  logic [2*CW-1:0]   q,
  input  logic [2*CW-1:0]   s,
  input  logic [2*CW+2:0]   u,
  input  logic [2*CW+1:0]   r2_main,
  input  logic [2*CW+1:0]   r2_minor,
  input  logic [CW-1:0]     mx,
  output logic              dn_valid,
  input  logic              dn_ready,
  output logic [4*CW+5:0]   lhs,
  output logic [4*CW+5:0]   rhs,
  output logic [2*CW-1:0]   slhs,
  output logic [2*CW+1:0]   srhs
);

  localparam int NS = 4;
  localparam int AW = 2*CW + 3;
  localparam int HL = CW + 2;
  localparam int HH = AW - HL;
  localparam int LW = 4*CW + 6;
  localparam int PW = 2*CW + 1;

  logic [NS-1:0]   vld;
  logic [NS-1:0]   ld;
  logic [2*CW-1:0] slhs_in;
  logic [2*CW+1:0] srhs_in;
  logic [AW-1:0]   a_in;
  // stage d
  logic [AW-1:0]   a_d;
  logic [2*CW-1:0] q_d;
  logic [2*CW+1:0] r2m_d;
  logic [2*CW-1:0] slhs_d, slhs_e, slhs_f;
  logic [2*CW+1:0] srhs_d, srhs_e, srhs_f;
  // stage e
  logic [2*HH-1:0] p_hh;
  logic [AW-1:0]   p_hl;
  logic [2*HL-1:0] p_ll;
  logic [PW-1:0]   p00, p01, p10, p11;
  // stage f
  logic [LW-1:0]   lhs_a, lhs_b, rhs_a, rhs_b;

  always_comb begin
    ld[NS-1] = !vld[NS-1] || dn_ready;
    for (int k = NS - 2; k >= 0; k--) begin
      ld[k] = !vld[k] || ld[k+1];
    end
  end

  assign up_ready = ld[0];
  assign dn_valid = vld[NS-1];

  always_comb begin
    if (u >= AW'(r2_minor)) begin
      a_in = u - AW'(r2_minor);
    end else begin
      a_in = AW'(r2_minor) - u;
    end
    case (ctrl.shape)
      SHAPE_SPHERE: begin
        slhs_in = s;
        srhs_in = r2_main;
      end
      SHAPE_CYLINDER: begin
        slhs_in = q;
        srhs_in = r2_main;
      end
      SHAPE_CUBE: begin
        slhs_in = (2*CW)'({mx, 1'b0});
        srhs_in = (2*CW+2)'(size_main);
      end
      default: begin
        slhs_in = '0;
        srhs_in = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (ld[0]) vld[0] <= up_valid;
      if (ld[1]) vld[1] <= vld[0];
      if (ld[2]) vld[2] <= vld[1];
      if (ld[3]) vld[3] <= vld[2];
    end
  end

  always_ff @(posedge clk) begin
    if (ld[0]) begin
      a_d    <= a_in;
      q_d    <= q;
      r2m_d  <= r2_main;
      slhs_d <= slhs_in;
      srhs_d <= srhs_in;
    end
    // half-width partial products
    if (ld[1]) begin
      p_hh   <= (2*HH)'(a_d[AW-1:HL]) * (2*HH)'(a_d[AW-1:HL]);
      p_hl   <= AW'(a_d[AW-1:HL]) * AW'(a_d[HL-1:0]);
      p_ll   <= (2*HL)'(a_d[HL-1:0]) * (2*HL)'(a_d[HL-1:0]);
      p00    <= PW'(r2m_d[CW:0]) * PW'(q_d[CW-1:0]);
      p01    <= PW'(r2m_d[CW:0]) * PW'(q_d[2*CW-1:CW]);
      p10    <= PW'(r2m_d[2*CW+1:CW+1]) * PW'(q_d[CW-1:0]);
      p11    <= PW'(r2m_d[2*CW+1:CW+1]) * PW'(q_d[2*CW-1:CW]);
      slhs_e <= slhs_d;
      srhs_e <= srhs_d;
    end
    if (ld[2]) begin
      lhs_a  <= (LW'(p_hh) << (2*HL)) + (LW'(p_hl) << (HL+1));
      lhs_b  <= LW'(p_ll);
      rhs_a  <= LW'(p00) + (LW'(p01) << CW);
      rhs_b  <= (LW'(p10) << (CW+1)) + (LW'(p11) << (2*CW+1));
      slhs_f <= slhs_e;
      srhs_f <= srhs_e;
    end
    if (ld[3]) begin
      lhs  <= lhs_a + lhs_b;
      rhs  <= (rhs_a + rhs_b) << 2;
      slhs <= slhs_f;
      srhs <= srhs_f;
    end
  end

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    vld[0] && !ld[0] |=> vld[0] && $stable(a_d) && $stable(slhs_d))
    else $error("stalled stage lost its contents");

endmodule

[hw/rtl/isp_decide.sv]
// final stages: signed difference, band or sign test, output register
// depends on isp_pkg; takes the compare pairs from isp_torus
module isp_decide import isp_pkg::*; #(
  parameter int CW = 16
) (
  input  logic              clk,
  input  logic              rst,
  input  cfg_ctrl_t         ctrl,
  input  logic [CW-1:0]     tolerance,
  input  logic              up_valid,
  output logic              up_ready,
  input  logic [4*CW+5:0]   lhs,
  input  logic [4*CW+5:0]   rhs,
  input  logic [2*CW-1:0]   slhs,
  input  logic [2*CW+1:0]   srhs,
  output logic              out_valid,
  input  logic              out_ready,
  output logic              accepted
);

  localparam int LW = 4*CW + 6;

  logic          vld_h;
  logic          ld_h, ld_o;
  logic [LW:0]   d_h;
  logic [LW-1:0] sel_l, sel_r, band;
  logic [LW+1:0] lo_sum;
  logic          hi_ok, lo_ok, vol_ok, ok;

  assign ld_o     = !out_valid || out_ready;
  assign ld_h     = !vld_h || ld_o;
  assign up_ready = ld_h;

  always_comb begin
    if (ctrl.shape == SHAPE_TORUS) begin
      sel_l = lhs;
      sel_r = rhs;
    end else begin
      sel_l = LW'(slhs);
      sel_r = LW'(srhs);
    end
    // band in the units of each shape's function
    case (ctrl.shape) inside
      SHAPE_SPHERE, SHAPE_CYLINDER: band = LW'(tolerance) << CW;
      SHAPE_CUBE:                   band = LW'(tolerance) << 1;
      default:                      band = LW'(tolerance) << (3*CW);
    endcase
    lo_sum = {d_h[LW], d_h} + {2'b00, band};
    lo_ok  = !lo_sum[LW+1];
    hi_ok  = $signed(d_h) <= $signed({1'b0, band});
    vol_ok = d_h[LW] || (d_h == '0);
    ok     = ctrl.surface ? (hi_ok && lo_ok) : vol_ok;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld_h     <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (ld_h) vld_h     <= up_valid;
      if (ld_o) out_valid <= vld_h;
    end
  end

  always_ff @(posedge clk) begin
    if (ld_h) begin
      d_h <= (LW+1)'(sel_l) - (LW+1)'(sel_r);
    end
    if (ld_o) begin
      accepted <= ok;
    end
  end

  a_zero_accept: assert property (@(posedge clk) disable iff (rst)
    vld_h && ld_o && (d_h == '0 || (!ctrl.surface && d_h[LW])) |=> accepted)
    else $error("point on or inside the shape was rejected");

endmodule

[tb/tb_implicit_shape_point_classifier.sv]
// self-checking bench for implicit_shape_point_classifier: a bit-exact predictor of the
// sphere, cylinder, cube and torus tests, a bursty point driver and a stalling result sink
// depends on isp_pkg and the classifier rtl only
module tb_implicit_shape_point_classifier;
  import isp_pkg::*;

  localparam int COORD_BITS   = 16;
  localparam int COORD_MAX    = (1 << (COORD_BITS - 1)) - 1;
  localparam int COORD_MIN    = -(1 << (COORD_BITS - 1));
  localparam int REG_COUNT    = REG_TOLERANCE + 1;
  localparam int RANDOM_ITEMS = 1100;
  localparam int DRAIN_CYCLES = 30;
  localparam int CYCLE_LIMIT  = 400000;

  typedef logic [127:0] wide_t;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] x;
    logic signed [COORD_BITS-1:0] y;
    logic signed [COORD_BITS-1:0] z;
  } point_t;

  typedef struct packed {
    point_t pt;
    logic   acc;
  } verdict_t;

  typedef enum logic [1:0] {
    RX_OPEN,
    RX_COIN,
    RX_PERIODIC,
    RX_CHOKE
  } rx_mode_t;

  logic                         clk = 1'b0;
  logic                         rst = 1'b1;
  logic                         cfg_valid = 1'b0;
  logic                         cfg_ready;
  logic [CFG_INDEX_BITS-1:0]    cfg_index = REG_SHAPE;
  logic [COORD_BITS:0]          cfg_data = '0;
  logic                         in_valid = 1'b0;
  logic                         in_ready;
  logic signed [COORD_BITS-1:0] point_x = '0;
  logic signed [COORD_BITS-1:0] point_y = '0;
  logic signed [COORD_BITS-1:0] point_z = '0;
  logic                         out_valid;
  logic                         out_ready = 1'b0;
  logic                         accepted;

  // shadow copy of the block's registers
  shape_t              cur_shape = SHAPE_SPHERE;
  logic                cur_surface = 1'b0;
  logic [COORD_BITS:0] cur_main = 17'd32768;
  logic [COORD_BITS:0] cur_minor = 17'd13107;
  logic [COORD_BITS-1:0] cur_tol = 16'd66;

  point_t   point_backlog[$];
  verdict_t verdict_q[$];
  int       mismatch_count = 0;
  int       cycle_count = 0;
  bit       point_beat_taken = 1'b0;
  int       burst_left = 0;
  int       gap_left = 0;
  point_t   drive_pt;
  verdict_t taken_verdict;
  verdict_t seen_verdict;

  rx_mode_t rx_mode = RX_OPEN;
  int       rx_left = 0;
  int       rx_period = 4;
  int       rx_duty = 2;
  int       rx_tick = 0;

  int       random_items = 0;
  int       phase_len;
  shape_t   rnd_shape;
  logic     rnd_surface;
  logic [COORD_BITS:0]   rnd_main;
  logic [COORD_BITS:0]   rnd_minor;
  logic [COORD_BITS-1:0] rnd_tol;

  implicit_shape_point_classifier #(
    .COORD_BITS(COORD_BITS)
  ) dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .point_x  (point_x),
    .point_y  (point_y),
    .point_z  (point_z),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .accepted (accepted)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic wide_t coord_mag(input logic signed [COORD_BITS-1:0] v);
    int iv;
    iv = int'(v);
    return wide_t'((iv < 0) ? -iv : iv);
  endfunction

  // exact membership test on 128-bit integers
  function automatic logic shape_verdict(input logic signed [COORD_BITS-1:0] px,
                                         input logic signed [COORD_BITS-1:0] py,
                                         input logic signed [COORD_BITS-1:0] pz);
    wide_t ax, ay, az, q, s, r2, rn2, t, a, m, lhs, rhs, band, diff;
    ax = coord_mag(px);
    ay = coord_mag(py);
    az = coord_mag(pz);
    q  = ax * ax + ay * ay;
    s  = q + az * az;
    r2 = wide_t'(cur_main) * wide_t'(cur_main);
    case (cur_shape)
      SHAPE_SPHERE: begin
        lhs  = s;
        rhs  = r2;
        band = wide_t'(cur_tol) << COORD_BITS;
      end
      SHAPE_CYLINDER: begin
        lhs  = q;
        rhs  = r2;
        band = wide_t'(cur_tol) << COORD_BITS;
      end
      SHAPE_CUBE: begin
        m = ax;
        if (ay > m) m = ay;
        if (az > m) m = az;
        // half-units so the full width compares without rounding
        lhs  = m << 1;
        rhs  = wide_t'(cur_main);
        band = wide_t'(cur_tol) << 1;
      end
      default: begin
        rn2  = wide_t'(cur_minor) * wide_t'(cur_minor);
        t    = s + r2;
        a    = (t >= rn2) ? t - rn2 : rn2 - t;
        lhs  = a * a;
        rhs  = (r2 * q) << 2;
        band = wide_t'(cur_tol) << (3 * COORD_BITS);
      end
    endcase
    if (cur_surface) begin
      diff = (lhs >= rhs) ? lhs - rhs : rhs - lhs;
      return diff <= band;
    end
    return lhs <= rhs;
  endfunction

  function automatic real unit_rand();
    return real'($urandom) / 4294967296.0;
  endfunction

  function automatic logic signed [COORD_BITS-1:0] jitter_coord(input real v, input int spread);
    int iv;
    iv = int'(v) + int'($urandom_range(0, 2 * spread)) - spread;
    if (iv > COORD_MAX) iv = COORD_MAX;
    else if (iv < COORD_MIN) iv = COORD_MIN;
    return iv[COORD_BITS-1:0];
  endfunction

  // a point on or near the surface of the current shape
  function automatic point_t shaped_point();
    real    rm, rn, th, ph, zc, rho, ring, half, sgn;
    real    cx, cy, cz;
    int     spread;
    int     face;
    point_t p;
    rm = cur_main;
    rn = cur_minor;
    th = 6.283185307 * unit_rand();
    ph = 6.283185307 * unit_rand();
    case ($urandom_range(0, 3))
      0: spread = 0;
      1: spread = 4;
      2: spread = 200;
      default: spread = 3000;
    endcase
    case (cur_shape)
      SHAPE_SPHERE: begin
        zc  = 2.0 * unit_rand() - 1.0;
        rho = $sqrt(1.0 - zc * zc);
        cx  = rm * rho * $cos(th);
        cy  = rm * rho * $sin(th);
        cz  = rm * zc;
      end
      SHAPE_CYLINDER: begin
        cx = rm * $cos(th);
        cy = rm * $sin(th);
        cz = (2.0 * unit_rand() - 1.0) * 32768.0;
      end
      SHAPE_CUBE: begin
        half = rm / 2.0;
        cx   = (2.0 * unit_rand() - 1.0) * half;
        cy   = (2.0 * unit_rand() - 1.0) * half;
        cz   = (2.0 * unit_rand() - 1.0) * half;
        sgn  = ($urandom_range(0, 1) != 0) ? half : -half;
        face = $urandom_range(0, 2);
        case (face)
          0: cx = sgn;
          1: cy = sgn;
          default: cz = sgn;
        endcase
      end
      default: begin
        ring = rm + rn * $cos(ph);
        cx   = ring * $cos(th);
        cy   = ring * $sin(th);
        cz   = rn * $sin(ph);
      end
    endcase
    p.x = jitter_coord(cx, spread);
    p.y = jitter_coord(cy, spread);
    p.z = jitter_coord(cz, spread);
    return p;
  endfunction

  task automatic report_mismatch(input string what);
    $display("mismatch at cycle %0d: %s", cycle_count, what);
    mismatch_count++;
  endtask

  // coordinates keep only their low COORD_BITS bits
  task automatic queue_point(input int x, input int y, input int z);
    point_t p;
    p.x = x[COORD_BITS-1:0];
    p.y = y[COORD_BITS-1:0];
    p.z = z[COORD_BITS-1:0];
    point_backlog = {point_backlog, p};
  endtask

  task automatic program_register(input logic [CFG_INDEX_BITS-1:0] idx,
                                  input logic [COORD_BITS:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_SHAPE:      cur_shape   = shape_t'(data[1:0]);
      REG_SURFACE:    cur_surface = data[0];
      REG_SIZE_MAIN:  cur_main    = data;
      REG_SIZE_MINOR: cur_minor   = data;
      REG_TOLERANCE:  cur_tol     = data[COORD_BITS-1:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // upper bits of the narrow registers carry junk to check the masking
  task automatic set_shape_cfg(input shape_t shape, input logic surface,
                               input logic [COORD_BITS:0] size_main,
                               input logic [COORD_BITS:0] size_minor,
                               input logic [COORD_BITS-1:0] tol);
    logic [COORD_BITS:0] junk;
    junk = (COORD_BITS+1)'($urandom);
    program_register(REG_SHAPE, {junk[COORD_BITS:2], shape});
    program_register(REG_SURFACE, {junk[COORD_BITS:1], surface});
    program_register(REG_SIZE_MAIN, size_main);
    program_register(REG_SIZE_MINOR, size_minor);
    program_register(REG_TOLERANCE, {junk[COORD_BITS], tol});
  endtask

  task automatic write_unused_regs();
    for (int i = REG_COUNT; i < (1 << CFG_INDEX_BITS); i++)
      program_register(CFG_INDEX_BITS'(i), (COORD_BITS+1)'($urandom));
  endtask

  // every queued point taken and every verdict returned
  task automatic await_idle();
    do @(posedge clk);
    while (point_backlog.size() != 0 || in_valid || verdict_q.size() != 0);
  endtask

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // point beat accepted: predict its verdict
  always @(posedge clk) begin
    point_beat_taken = !rst && in_valid && in_ready;
    if (point_beat_taken) begin
      taken_verdict.pt  = {point_x, point_y, point_z};
      taken_verdict.acc = shape_verdict(point_x, point_y, point_z);
      verdict_q = {verdict_q, taken_verdict};
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (verdict_q.size() == 0) begin
        report_mismatch($sformatf("result beat with nothing outstanding, accepted=%0b",
                                  accepted));
      end else begin
        seen_verdict = verdict_q.pop_front();
        if (accepted !== seen_verdict.acc)
          report_mismatch($sformatf("point (%0d,%0d,%0d) accepted=%0b, predicted %0b",
                                    seen_verdict.pt.x, seen_verdict.pt.y,
                                    seen_verdict.pt.z, accepted, seen_verdict.acc));
      end
    end
  end

  // sender: bursts of points separated by random gaps
  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (in_valid && !point_beat_taken) begin
      // hold the beat until it is taken
    end else if (gap_left > 0) begin
      in_valid <= 1'b0;
      gap_left--;
    end else if (point_backlog.size() != 0) begin
      drive_pt = point_backlog.pop_front();
      point_x  <= drive_pt.x;
      point_y  <= drive_pt.y;
      point_z  <= drive_pt.z;
      in_valid <= 1'b1;
      if (burst_left > 0) begin
        burst_left--;
      end else begin
        burst_left = $urandom_range(1, 40);
        case ($urandom_range(0, 3))
          0: gap_left = 0;
          1: gap_left = $urandom_range(1, 3);
          2: gap_left = $urandom_range(4, 10);
          default: gap_left = $urandom_range(0, 1) * 20;
        endcase
      end
    end else begin
      in_valid <= 1'b0;
    end
  end

  // receiver: stall pattern switches between open, coin-toss, periodic and choked
  always @(negedge clk) begin
    if (rx_left == 0) begin
      rx_mode   = rx_mode_t'($urandom_range(0, 3));
      rx_left   = $urandom_range(20, 200);
      rx_period = $urandom_range(2, 12);
      rx_duty   = $urandom_range(1, rx_period - 1);
    end else begin
      rx_left--;
    end
    rx_tick++;
    case (rx_mode)
      RX_OPEN:     out_ready <= 1'b1;
      RX_COIN:     out_ready <= ($urandom_range(0, 2) != 0);
      RX_PERIODIC: out_ready <= ((rx_tick % rx_period) < rx_duty);
      default:     out_ready <= ($urandom_range(0, 15) == 0);
    endcase
  end

  initial begin
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // reset setting: sphere of radius one half, volume test, corner and boundary points
    queue_point(COORD_MIN, COORD_MIN, COORD_MIN);
    queue_point(COORD_MAX, COORD_MAX, COORD_MAX);
    queue_point(0, 0, 0);
    queue_point(COORD_MIN, 0, 0);
    queue_point(0, COORD_MIN, 1);
    await_idle();

    // cube band edges: |2m - width| against twice the tolerance
    set_shape_cfg(SHAPE_CUBE, 1'b1, 17'd20000, 17'd13107, 16'd100);
    queue_point(10100, 0, 0);
    queue_point(0, -10101, 5);
    queue_point(-9900, 3, 3);
    queue_point(9899, 0, 0);
    await_idle();

    set_shape_cfg(SHAPE_CUBE, 1'b0, 17'd20000, 17'd13107, 16'd100);
    queue_point(10000, 0, 0);
    queue_point(0, 0, -10001);
    await_idle();

    set_shape_cfg(SHAPE_CYLINDER, 1'b0, 17'd16384, 17'd13107, 16'd66);
    queue_point(16384, 0, COORD_MAX);
    queue_point(0, -16385, 0);
    await_idle();

    set_shape_cfg(SHAPE_CYLINDER, 1'b1, 17'd16384, 17'd0, 16'd65535);
    queue_point(16384, 0, 0);
    queue_point(20000, 0, COORD_MIN);
    await_idle();

    // torus: ring centre inside, origin outside, top of the tube exactly on the surface
    set_shape_cfg(SHAPE_TORUS, 1'b0, 17'd19661, 17'd13107, 16'd66);
    queue_point(19661, 0, 0);
    queue_point(0, 0, 0);
    queue_point(0, 19661, 13107);
    await_idle();

    set_shape_cfg(SHAPE_TORUS, 1'b1, 17'd19661, 17'd13107, 16'd66);
    queue_point(0, 19661, 13107);
    queue_point(19661, 0, 0);
    await_idle();

    // zero tolerance accepts only the exact surface
    set_shape_cfg(SHAPE_SPHERE, 1'b1, 17'd32768, 17'd13107, 16'd0);
    queue_point(COORD_MIN, 0, 0);
    queue_point(COORD_MAX, 0, 0);
    await_idle();

    // writes beyond the register list must leave the setting alone
    write_unused_regs();
    queue_point(0, 0, 0);
    await_idle();

    while (random_items < RANDOM_ITEMS) begin
      rnd_shape   = shape_t'($urandom_range(0, 3));
      rnd_surface = 1'($urandom_range(0, 1));
      case ($urandom_range(0, 9))
        0: rnd_main = '0;
        1: rnd_main = '1;
        2: rnd_main = 17'd65536;
        3: rnd_main = (COORD_BITS+1)'($urandom);
        default: rnd_main = (COORD_BITS+1)'($urandom_range(4000, 40000));
      endcase
      case ($urandom_range(0, 7))
        0: rnd_minor = '0;
        1: rnd_minor = '1;
        2: rnd_minor = (COORD_BITS+1)'($urandom);
        default: rnd_minor = (COORD_BITS+1)'($urandom_range(2000, 16000));
      endcase
      case ($urandom_range(0, 7))
        0: rnd_tol = '0;
        1: rnd_tol = '1;
        2: rnd_tol = COORD_BITS'($urandom);
        default: rnd_tol = COORD_BITS'($urandom_range(0, 400));
      endcase
      set_shape_cfg(rnd_shape, rnd_surface, rnd_main, rnd_minor, rnd_tol);
      if ($urandom_range(0, 3) == 0)
        write_unused_regs();
      phase_len = $urandom_range(40, 120);
      for (int k = 0; k < phase_len; k++) begin
        if ($urandom_range(0, 3) == 0)
          queue_point(int'($urandom), int'($urandom), int'($urandom));
        else
          point_backlog = {point_backlog, shaped_point()};
      end
      random_items += phase_len;
      await_idle();
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (verdict_q.size() != 0)
      report_mismatch($sformatf("%0d verdicts never returned", verdict_q.size()));
    if (mismatch_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
